// ===== rtl/rsqe_pkg.sv =====
// Shared types, constants and helpers for the rotated sprite quad expander.
package rsqe_pkg;

	localparam int unsigned COUNT_W  = 13;
	localparam int unsigned INDEX_W  = 14;
	localparam int unsigned COORD_W  = 16;
	localparam int unsigned TRIG_W   = 17;
	localparam int unsigned CORNER_W = 17;
	localparam int unsigned PROD_W   = 34;
	localparam int unsigned SUM_W    = 35;
	localparam int unsigned ROUND_W  = 20;
	localparam int unsigned OFFS_W   = 21;

	localparam logic [COUNT_W-1:0] LIMIT_RESET = 13'd4096;

	// Taylor series constants in Q2.30.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_TR = 2'd1;
	localparam logic [1:0] CORNER_BR = 2'd2;
	localparam logic [1:0] CORNER_BL = 2'd3;

	typedef struct packed {
		logic [63:0]        uv_rect;
		logic [31:0]        color;
		logic [15:0]        angle;
		logic signed [15:0] pivot_y;
		logic signed [15:0] pivot_x;
		logic signed [15:0] height;
		logic signed [15:0] width;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_x;
	} sprite_t;

	typedef struct packed {
		logic [1:0]         pad;
		logic [31:0]        vertex_color;
		logic [15:0]        tex_v;
		logic [15:0]        tex_u;
		logic signed [15:0] vy;
		logic signed [15:0] vx;
		logic [13:0]        vertex_index;
	} vertex_t;

	localparam int unsigned S_DATA_W = $bits(sprite_t);
	localparam int unsigned M_DATA_W = $bits(vertex_t);

	function automatic logic signed [COORD_W-1:0] sat16(input logic signed [OFFS_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > 21'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -21'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/rotated_sprite_quad_expander.sv =====
// Top level: expands each kept sprite word into the four vertex words of a rotated quad.
//
// Usage:
//   s_tdata carries one sprite per word; s_tuser marks the first sprite of a frame
//   and clears the sprite counter before that sprite is handled.
//   m_tdata carries one vertex per word, four per kept sprite, in the order
//   top-left, top-right, bottom-right, bottom-left; m_tlast marks the fourth.
//   cfg_valid/cfg_data write the per-frame sprite limit; cfg_ready is always high.
//   Sprites past the limit are taken and produce no words.
// Timing:
//   A kept sprite passes the input register, corner stage, product stage and output
//   register; its words follow one per cycle while m_tready is high. A new sprite
//   leaves the input register once the corner stage is idle or on its last corner.
// Reset:
//   The limit returns to 4096, the counter to zero, and all stages empty.
// Stall:
//   While m_tready is low the output word holds; the pipeline stages fill and
//   s_tready drops once the input register can no longer advance.
module rotated_sprite_quad_expander #(
	parameter int unsigned MAX_SPRITES      = 4096,
	parameter int unsigned SINE_TABLE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rsqe_pkg::COUNT_W-1:0]  cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// pos_x, pos_y, width, height, pivot_x, pivot_y, angle, color, uv_rect
	input  logic [rsqe_pkg::S_DATA_W-1:0] s_tdata,
	// frame_start
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// vertex_index, vx, vy, tex_u, tex_v, vertex_color, two zero bits
	output logic [rsqe_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast
);
	import rsqe_pkg::*;

	localparam int unsigned IW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int unsigned PW = 14 + IW;
	localparam logic [16:0] MAX_LIM = 17'(MAX_SPRITES);

	// Quarter-wave sine table, Q1.15, built at elaboration.
	logic [15:0] sine_tbl [0:SINE_TABLE_DEPTH];

	for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_tbl
		localparam logic [63:0] X  = (HALF_PI_Q30 * 64'(gi) + 64'(SINE_TABLE_DEPTH / 2))
			/ 64'(SINE_TABLE_DEPTH);
		localparam logic [63:0] X2 = (X * X) >> 30;
		localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
		localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
		localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
		localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
		localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
		localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
		localparam logic signed [63:0] SUM = $signed(X) - $signed(T1) + $signed(T2)
			- $signed(T3) + $signed(T4) - $signed(T5) + $signed(T6);
		localparam logic [63:0] SUMC = (SUM < 0) ? 64'd0 :
			(SUM > $signed(Q30_ONE)) ? Q30_ONE : 64'(SUM);
		localparam logic [63:0] VAL = ((SUMC << 15) + (64'd1 << 29)) >> 30;
		assign sine_tbl[gi] = VAL[15:0];
	end

	// Configuration and sprite counter.
	logic [COUNT_W-1:0] limit_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] cnt_base;
	logic               keep;
	logic               s_acc;

	assign cfg_ready = 1'b1;
	assign s_acc     = s_tvalid && s_tready;
	assign cnt_base  = s_tuser ? '0 : count_q;
	assign keep      = ({4'b0, cnt_base} < {4'b0, limit_q}) && ({4'b0, cnt_base} < MAX_LIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			count_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (s_acc) begin
				count_q <= keep ? cnt_base + COUNT_W'(1) : cnt_base;
			end
		end
	end

	// Stage control.
	logic       v1_q, v2_q, v3_q, mv_q;
	logic [1:0] corner_q;
	logic       out_rdy, s3_adv, s3_free, issue, s2_done, s2_free, s1_adv;

	assign out_rdy  = !mv_q || m_tready;
	assign s3_adv   = v3_q && out_rdy;
	assign s3_free  = !v3_q || out_rdy;
	assign issue    = v2_q && s3_free;
	assign s2_done  = issue && (corner_q == CORNER_BL);
	assign s2_free  = !v2_q || s2_done;
	assign s1_adv   = v1_q && s2_free;
	assign s_tready = !v1_q || s2_free;
	assign m_tvalid = mv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			v3_q     <= 1'b0;
			mv_q     <= 1'b0;
			corner_q <= CORNER_TL;
		end else begin
			if (s_acc) begin
				v1_q <= keep;
			end else if (s1_adv) begin
				v1_q <= 1'b0;
			end
			if (s1_adv) begin
				v2_q     <= 1'b1;
				corner_q <= CORNER_TL;
			end else if (s2_done) begin
				v2_q <= 1'b0;
			end else if (issue) begin
				corner_q <= corner_q + 2'd1;
			end
			if (issue) begin
				v3_q <= 1'b1;
			end else if (s3_adv) begin
				v3_q <= 1'b0;
			end
			if (s3_adv) begin
				mv_q <= 1'b1;
			end else if (m_tready) begin
				mv_q <= 1'b0;
			end
		end
	end

	// Stage 1: input register.
	sprite_t            spr_s1;
	logic [INDEX_W-1:0] base_s1;

	always_ff @(posedge clk) begin
		if (s_acc) begin
			spr_s1  <= sprite_t'(s_tdata);
			base_s1 <= {cnt_base[INDEX_W-3:0], 2'b00};
		end
	end

	// Table lookup and corner offsets for the sprite in stage 1.
	logic [PW-1:0]              phase_prod;
	logic [IW-1:0]              idx;
	logic signed [TRIG_W-1:0]   sv, cv, sn, cs;

	assign phase_prod = PW'(spr_s1.angle[13:0]) * PW'(SINE_TABLE_DEPTH);
	assign idx        = IW'(phase_prod >> 14);
	assign sv         = $signed({1'b0, sine_tbl[idx]});
	assign cv         = $signed({1'b0, sine_tbl[IW'(SINE_TABLE_DEPTH) - idx]});

	always_comb begin
		case (spr_s1.angle[15:14])
			QUAD_I: begin
				sn = sv;
				cs = cv;
			end
			QUAD_II: begin
				sn = cv;
				cs = -sv;
			end
			QUAD_III: begin
				sn = -sv;
				cs = -cv;
			end
			default: begin
				sn = -cv;
				cs = sv;
			end
		endcase
	end

	// Stage 2: one sprite, walked corner by corner.
	logic signed [TRIG_W-1:0]   sn_s2, cs_s2;
	logic signed [CORNER_W-1:0] cxa_s2, cxb_s2, cya_s2, cyb_s2;
	logic signed [COORD_W-1:0]  px_s2, py_s2;
	logic [63:0]                uv_s2;
	logic [31:0]                color_s2;
	logic [INDEX_W-1:0]         base_s2;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			sn_s2    <= sn;
			cs_s2    <= cs;
			cxa_s2   <= -CORNER_W'(spr_s1.pivot_x);
			cxb_s2   <= CORNER_W'(spr_s1.width) - CORNER_W'(spr_s1.pivot_x);
			cya_s2   <= -CORNER_W'(spr_s1.pivot_y);
			cyb_s2   <= CORNER_W'(spr_s1.height) - CORNER_W'(spr_s1.pivot_y);
			px_s2    <= spr_s1.pos_x;
			py_s2    <= spr_s1.pos_y;
			uv_s2    <= spr_s1.uv_rect;
			color_s2 <= spr_s1.color;
			base_s2  <= base_s1;
		end
	end

	logic                       left_c, top_c;
	logic signed [PROD_W-1:0]   cx_w, cy_w, sn_w, cs_w;

	assign left_c = (corner_q == CORNER_TL) || (corner_q == CORNER_BL);
	assign top_c  = (corner_q == CORNER_TL) || (corner_q == CORNER_TR);
	assign cx_w   = PROD_W'(left_c ? cxa_s2 : cxb_s2);
	assign cy_w   = PROD_W'(top_c ? cya_s2 : cyb_s2);
	assign sn_w   = PROD_W'(sn_s2);
	assign cs_w   = PROD_W'(cs_s2);

	// Stage 3: the four products of one corner.
	logic signed [PROD_W-1:0]  xc_s3, ys_s3, xs_s3, yc_s3;
	logic signed [COORD_W-1:0] px_s3, py_s3;
	logic [15:0]               u_s3, v_s3;
	logic [31:0]               color_s3;
	logic [INDEX_W-1:0]        index_s3;
	logic                      last_s3;

	always_ff @(posedge clk) begin
		if (issue) begin
			xc_s3    <= cx_w * cs_w;
			ys_s3    <= cy_w * sn_w;
			xs_s3    <= cx_w * sn_w;
			yc_s3    <= cy_w * cs_w;
			px_s3    <= px_s2;
			py_s3    <= py_s2;
			u_s3     <= left_c ? uv_s2[15:0] : uv_s2[47:32];
			v_s3     <= top_c ? uv_s2[31:16] : uv_s2[63:48];
			color_s3 <= color_s2;
			index_s3 <= {base_s2[INDEX_W-1:2], corner_q};
			last_s3  <= (corner_q == CORNER_BL);
		end
	end

	// Sum, round half up from Q1.15 trig scale to coordinate units, offset by the position and saturate.
	logic signed [SUM_W-1:0]   rx_e, ry_e;
	logic signed [ROUND_W-1:0] rx_r, ry_r;
	vertex_t                   vtx;

	assign rx_e = SUM_W'(xc_s3) - SUM_W'(ys_s3);
	assign ry_e = SUM_W'(xs_s3) + SUM_W'(yc_s3);
	assign rx_r = ROUND_W'((rx_e + 35'sd16384) >>> 15);
	assign ry_r = ROUND_W'((ry_e + 35'sd16384) >>> 15);

	always_comb begin
		vtx.pad          = '0;
		vtx.vertex_color = color_s3;
		vtx.tex_v        = v_s3;
		vtx.tex_u        = u_s3;
		vtx.vy           = sat16(OFFS_W'(ry_r) + OFFS_W'(py_s3));
		vtx.vx           = sat16(OFFS_W'(rx_r) + OFFS_W'(px_s3));
		vtx.vertex_index = index_s3;
	end

	// Output register.
	vertex_t out_q;
	logic    last_q;

	always_ff @(posedge clk) begin
		if (s3_adv) begin
			out_q  <= vtx;
			last_q <= last_s3;
		end
	end

	assign m_tdata = M_DATA_W'(out_q);
	assign m_tlast = last_q;

endmodule

// ===== rtl/rsqe_checker.sv =====
// Port-level checker for the rotated sprite quad expander, bound to the top level.
module rsqe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rsqe_pkg::M_DATA_W-1:0] m_tdata,
	input logic                          m_tlast
);
	import rsqe_pkg::*;

	logic [INDEX_W-1:0] prev_idx_q;
	logic               mid_q;
	logic               m_acc;

	assign m_acc = m_tvalid && m_tready;

	// Tracks whether the last word taken was inside a sprite, and its index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q      <= 1'b0;
			prev_idx_q <= '0;
		end else if (m_acc) begin
			mid_q      <= !m_tlast;
			prev_idx_q <= m_tdata[INDEX_W-1:0];
		end
	end

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output word shown during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output word changed");

	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[1:0] == CORNER_BL)))
		else $error("last flag does not match the corner");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && mid_q |-> m_tdata[INDEX_W-1:0] == prev_idx_q + INDEX_W'(1))
		else $error("vertex index did not step within a sprite");

endmodule

bind rotated_sprite_quad_expander rsqe_checker u_rsqe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
